// ===== rtl/core/bse_pkg.sv =====
// Shared constants, types and helper functions of the bitmap search engine.
`default_nettype none

package bse_pkg;

    localparam int NUM_CHUNKS = 64;
    localparam int CHUNK_BITS = 32;
    localparam int ADDR_W     = $clog2(NUM_CHUNKS);
    localparam int OFF_W      = $clog2(CHUNK_BITS);
    localparam int NCHUNK_W   = 7;
    localparam int POS_W      = 11;
    localparam int COUNT_W    = 12;
    localparam int POP_W      = $clog2(CHUNK_BITS + 1);

    localparam logic [3:0] OP_WRITE  = 4'd0;
    localparam logic [3:0] OP_OR     = 4'd1;
    localparam logic [3:0] OP_AND    = 4'd2;
    localparam logic [3:0] OP_XOR    = 4'd3;
    localparam logic [3:0] OP_INVERT = 4'd4;
    localparam logic [3:0] OP_CLEAR  = 4'd5;
    localparam logic [3:0] OP_FILL   = 4'd6;
    localparam logic [3:0] OP_COUNT  = 4'd7;
    localparam logic [3:0] OP_FSET   = 4'd8;
    localparam logic [3:0] OP_FZERO  = 4'd9;
    localparam logic [3:0] OP_READ   = 4'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fetch;
        logic modify;
        logic sweep;
        logic scan;
        logic load_out;
    } bse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic sweep_last;
        logic scan_done;
    } bse_stat_t;

    function automatic logic [POP_W-1:0] pop_count(input logic [CHUNK_BITS-1:0] v);
        logic [POP_W-1:0] c;
        c = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            c = c + POP_W'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [OFF_W-1:0] lowest_one(input logic [CHUNK_BITS-1:0] v);
        logic [OFF_W-1:0] b;
        b = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = OFF_W'(i);
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bse_ctrl.sv =====
// Controller state machine of the bitmap search engine.
`default_nettype none

module bse_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [3:0]      command,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire bse_pkg::bse_stat_t stat,
    output bse_pkg::bse_cmd_t    cmd
);
    import bse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_MODIFY = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        OP_WRITE, OP_OR, OP_AND, OP_XOR, OP_INVERT, OP_READ:
                            state_next = S_FETCH;
                        OP_CLEAR, OP_FILL:
                            state_next = stat.n_zero ? S_DONE : S_SWEEP;
                        OP_COUNT, OP_FSET, OP_FZERO:
                            state_next = S_SCAN;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an item is in work");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready)
        |=> (state_reg == S_DONE && out_valid_reg))
        else $error("pending result overwritten");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.scan_done) |=> (state_reg == S_DONE))
        else $error("scan did not finish");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bse_datapath.sv =====
// Datapath of the bitmap search engine: chunk store, scan pipeline and result registers.
`default_nettype none

module bse_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         chunks_in_use_we,
    input  wire logic [bse_pkg::NCHUNK_W-1:0] chunks_in_use,
    input  wire logic [3:0]                   command,
    input  wire logic [bse_pkg::ADDR_W-1:0]   chunk_index,
    input  wire logic [31:0]                  chunk_data,
    input  wire logic [bse_pkg::POS_W-1:0]    start_bit,
    input  wire bse_pkg::bse_cmd_t            cmd,
    output bse_pkg::bse_stat_t                stat,
    output logic [31:0]                       read_data,
    output logic [bse_pkg::COUNT_W-1:0]       bit_count,
    output logic [bse_pkg::POS_W-1:0]         bit_index,
    output logic                              found
);
    import bse_pkg::*;

    logic [CHUNK_BITS-1:0] mem [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0] vld_reg, vld_next;
    logic [CHUNK_BITS-1:0] mem_rd_reg;
    logic                  vld_rd_reg;

    logic [NCHUNK_W-1:0]   cfg_reg;
    logic [3:0]            op_reg;
    logic [ADDR_W-1:0]     idx_reg;
    logic [31:0]           data_reg;
    logic [POS_W-1:0]      start_reg;

    logic [NCHUNK_W-1:0]   addr_reg, addr_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_idx_reg;

    logic [31:0]           rd_acc_reg;
    logic [COUNT_W-1:0]    cnt_acc_reg;
    logic [POS_W-1:0]      pos_acc_reg;
    logic                  fnd_acc_reg;

    logic [NCHUNK_W-1:0]   n_cov;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  mem_we;
    logic                  mem_re;
    logic [CHUNK_BITS-1:0] mem_wdata;
    logic [CHUNK_BITS-1:0] chunk_word;
    logic [CHUNK_BITS-1:0] srch_word;
    logic                  is_find;
    logic                  is_zero;
    logic                  can_issue;
    logic                  issue;
    logic                  hit;
    logic [ADDR_W-1:0]     first_chunk;

    assign n_cov = (cfg_reg > NCHUNK_W'(NUM_CHUNKS)) ? NCHUNK_W'(NUM_CHUNKS) : cfg_reg;
    assign first_chunk = start_reg[POS_W-1:OFF_W];
    assign is_find = (op_reg == OP_FSET) || (op_reg == OP_FZERO);
    assign is_zero = (op_reg == OP_FZERO);

    // A never-written entry reads as zero through its valid bit.
    assign chunk_word = vld_rd_reg ? mem_rd_reg : '0;

    always_comb
    begin
        srch_word = is_zero ? ~chunk_word : chunk_word;
        if (pend_idx_reg == first_chunk)
        begin
            srch_word = srch_word & ({CHUNK_BITS{1'b1}} << start_reg[OFF_W-1:0]);
        end
    end

    assign hit       = cmd.scan && pend_reg && is_find && (srch_word != '0);
    assign can_issue = (addr_reg < n_cov);
    assign issue     = cmd.scan && can_issue && !hit;

    assign stat.n_zero     = (n_cov == '0);
    assign stat.sweep_last = (addr_reg == n_cov - NCHUNK_W'(1));
    assign stat.scan_done  = hit || (!pend_reg && !can_issue);

    assign mem_addr = (cmd.sweep || cmd.scan) ? addr_reg[ADDR_W-1:0] : idx_reg;
    assign mem_we   = cmd.modify && (op_reg != OP_READ) || cmd.sweep;
    assign mem_re   = cmd.fetch || cmd.scan;

    always_comb
    begin
        mem_wdata = '0;
        if (cmd.sweep)
        begin
            mem_wdata = (op_reg == OP_FILL) ? '1 : '0;
        end
        else
        begin
            case (op_reg)
                OP_WRITE:  mem_wdata = data_reg;
                OP_OR:     mem_wdata = chunk_word | data_reg;
                OP_AND:    mem_wdata = chunk_word & data_reg;
                OP_XOR:    mem_wdata = chunk_word ^ data_reg;
                OP_INVERT: mem_wdata = ~data_reg;
                default:   mem_wdata = chunk_word;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (mem_we)
        begin
            vld_next[mem_addr] = 1'b1;
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        pend_next = pend_reg;
        if (cmd.accept)
        begin
            addr_next = ((command == OP_FSET) || (command == OP_FZERO))
                        ? NCHUNK_W'(start_bit[POS_W-1:OFF_W]) : '0;
            pend_next = 1'b0;
        end
        else if (cmd.sweep)
        begin
            addr_next = addr_reg + NCHUNK_W'(1);
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                addr_next = addr_reg + NCHUNK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= NCHUNK_W'(NUM_CHUNKS);
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
            pend_reg   <= 1'b0;
            addr_reg   <= '0;
        end
        else
        begin
            if (chunks_in_use_we)
            begin
                cfg_reg <= chunks_in_use;
            end
            vld_reg    <= vld_next;
            if (mem_re)
            begin
                vld_rd_reg <= vld_reg[mem_addr];
            end
            pend_reg   <= pend_next;
            addr_reg   <= addr_next;
        end
    end

    // Item capture, accumulators and the output register.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= addr_reg[ADDR_W-1:0];
        if (cmd.accept)
        begin
            op_reg      <= command;
            idx_reg     <= chunk_index;
            data_reg    <= chunk_data;
            start_reg   <= start_bit;
            rd_acc_reg  <= '0;
            cnt_acc_reg <= '0;
            pos_acc_reg <= '0;
            fnd_acc_reg <= 1'b0;
        end
        else
        begin
            if (cmd.modify && (op_reg == OP_READ))
            begin
                rd_acc_reg <= chunk_word;
            end
            if (cmd.scan && pend_reg && (op_reg == OP_COUNT))
            begin
                cnt_acc_reg <= cnt_acc_reg + COUNT_W'(pop_count(chunk_word));
            end
            if (hit)
            begin
                pos_acc_reg <= {pend_idx_reg, lowest_one(srch_word)};
                fnd_acc_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            read_data <= rd_acc_reg;
            bit_count <= cnt_acc_reg;
            bit_index <= pos_acc_reg;
            found     <= fnd_acc_reg;
        end
    end

`ifndef SYNTHESIS
    a_hit_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> fnd_acc_reg)
        else $error("find hit not recorded");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !mem_we)
        else $error("store written during a scan");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> vld_reg[$past(mem_addr)])
        else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_search_engine_core.sv =====
// Top level of the bitmap search engine: controller and datapath.
// Write, logic and read commands pass through fetch, modify and done; clear and fill sweep
// the covered chunks and go straight to done with no covered chunk, as unused codes do; count
// and find scan the covered chunks, read one per cycle from the store.
// One item at a time: the next input can be taken in the cycle after the result loads, and a
// result waits while the previous one is still untaken. Reset clears all valid bits at once.
`default_nettype none

module bitmap_search_engine_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         chunks_in_use_we,
    input  wire logic [bse_pkg::NCHUNK_W-1:0] chunks_in_use,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [3:0]                   command,
    input  wire logic [bse_pkg::ADDR_W-1:0]   chunk_index,
    input  wire logic [31:0]                  chunk_data,
    input  wire logic [bse_pkg::POS_W-1:0]    start_bit,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [31:0]                       read_data,
    output logic [bse_pkg::COUNT_W-1:0]       bit_count,
    output logic [bse_pkg::POS_W-1:0]         bit_index,
    output logic                              found
);
    import bse_pkg::*;

    bse_cmd_t  cmd;
    bse_stat_t stat;

    bse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bse_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .chunks_in_use_we (chunks_in_use_we),
        .chunks_in_use    (chunks_in_use),
        .command          (command),
        .chunk_index      (chunk_index),
        .chunk_data       (chunk_data),
        .start_bit        (start_bit),
        .cmd              (cmd),
        .stat             (stat),
        .read_data        (read_data),
        .bit_count        (bit_count),
        .bit_index        (bit_index),
        .found            (found)
    );

endmodule

`default_nettype wire

// ===== sim/bitmap_result_checker.sv =====
// Result checker for the bitmap search engine: mirrors the bitmap and compares every result.
`timescale 1ns / 1ps

module bitmap_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         chunks_in_use_we,
    input  logic [bse_pkg::NCHUNK_W-1:0] chunks_in_use,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [3:0]                   command,
    input  logic [bse_pkg::ADDR_W-1:0]   chunk_index,
    input  logic [31:0]                  chunk_data,
    input  logic [bse_pkg::POS_W-1:0]    start_bit,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [31:0]                  read_data,
    input  logic [bse_pkg::COUNT_W-1:0]  bit_count,
    input  logic [bse_pkg::POS_W-1:0]    bit_index,
    input  logic                         found,
    output int                           mismatch_count,
    output int                           results_waiting,
    output int                           results_checked
);
    import bse_pkg::*;

    typedef struct packed {
        logic [31:0]        read_data;
        logic [COUNT_W-1:0] bit_count;
        logic [POS_W-1:0]   bit_index;
        logic               found;
    } bse_result_t;

    logic [CHUNK_BITS-1:0] shadow_map [NUM_CHUNKS];
    logic [NCHUNK_W-1:0]   shadow_span;
    bse_result_t           expected_results [$];
    int                    mismatches = 0;
    int                    checked = 0;

    function automatic int covered_chunks();
        return (shadow_span > NUM_CHUNKS) ? NUM_CHUNKS : int'(shadow_span);
    endfunction

    // Scans for a one, or for a zero when want_zero is set, from from_bit upward.
    function automatic logic find_first(input logic want_zero, input logic [POS_W-1:0] from_bit,
                                        output logic [POS_W-1:0] where);
        int                    first_chunk;
        int                    b;
        logic [CHUNK_BITS-1:0] w;
        logic [CHUNK_BITS-1:0] keep;
        first_chunk = from_bit / CHUNK_BITS;
        where = '0;
        for (int c = first_chunk; c < covered_chunks(); c++)
        begin
            w = want_zero ? ~shadow_map[c] : shadow_map[c];
            if (c == first_chunk)
            begin
                keep = '1;
                keep = keep << (from_bit % CHUNK_BITS);
                w = w & keep;
            end
            if (w != '0)
            begin
                b = 0;
                while (!w[b])
                    b++;
                where = POS_W'(c * CHUNK_BITS + b);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bse_result_t predict_command(input logic [3:0] op,
                                                    input logic [ADDR_W-1:0] idx,
                                                    input logic [31:0] data,
                                                    input logic [POS_W-1:0] from_bit);
        bse_result_t res;
        int          total;
        res = '0;
        total = 0;
        case (op)
            OP_WRITE:  shadow_map[idx] = data;
            OP_OR:     shadow_map[idx] = shadow_map[idx] | data;
            OP_AND:    shadow_map[idx] = shadow_map[idx] & data;
            OP_XOR:    shadow_map[idx] = shadow_map[idx] ^ data;
            OP_INVERT: shadow_map[idx] = ~data;
            OP_CLEAR:
            begin
                for (int i = 0; i < covered_chunks(); i++)
                    shadow_map[i] = '0;
            end
            OP_FILL:
            begin
                for (int i = 0; i < covered_chunks(); i++)
                    shadow_map[i] = '1;
            end
            OP_COUNT:
            begin
                for (int i = 0; i < covered_chunks(); i++)
                    total += $countones(shadow_map[i]);
                res.bit_count = (total > (1 << COUNT_W) - 1) ? '1 : COUNT_W'(total);
            end
            OP_FSET:  res.found = find_first(1'b0, from_bit, res.bit_index);
            OP_FZERO: res.found = find_first(1'b1, from_bit, res.bit_index);
            OP_READ:  res.read_data = shadow_map[idx];
            default:  ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bse_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHUNKS; i++)
                shadow_map[i] = '0;
            shadow_span = NCHUNK_W'(NUM_CHUNKS);
            expected_results.delete();
            results_waiting <= 0;
        end
        else
        begin
            // The result leaving now belongs to an earlier transfer, so pop before pushing.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("bit_count", 32'(want.bit_count), 32'(bit_count));
                    check_field("bit_index", 32'(want.bit_index), 32'(bit_index));
                    check_field("found", 32'(want.found), 32'(found));
                    checked++;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_command(command, chunk_index, chunk_data,
                                                           start_bit));
            if (chunks_in_use_we)
                shadow_span = chunks_in_use;
            results_waiting <= expected_results.size();
        end
        mismatch_count  <= mismatches;
        results_checked <= checked;
    end

endmodule

// ===== sim/tb_bitmap_search_engine_core.sv =====
// Testbench top for the bitmap search engine: drives commands and span settings, gives the verdict.
`timescale 1ns / 1ps

module tb_bitmap_search_engine_core;

    import bse_pkg::*;

    localparam logic [3:0] CMD_FIRST_SPARE = OP_READ + 4'd1;
    localparam logic [3:0] CMD_TOP         = '1;
    localparam int         STALL_LIMIT     = 3000;
    localparam int         MAX_GAP         = 24;
    localparam int         BLOCK_ITEMS     = 50;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                chunks_in_use_we = 1'b0;
    logic [NCHUNK_W-1:0] chunks_in_use = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [3:0]          command = OP_READ;
    logic [ADDR_W-1:0]   chunk_index = '0;
    logic [31:0]         chunk_data = '0;
    logic [POS_W-1:0]    start_bit = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [31:0]         read_data;
    logic [COUNT_W-1:0]  bit_count;
    logic [POS_W-1:0]    bit_index;
    logic                found;

    int mismatch_count;
    int results_waiting;
    int results_checked;
    int send_idle_pct = 27;
    int recv_idle_pct = 73;
    int commands_sent = 0;
    int span_settings = 0;
    int cur_span = NUM_CHUNKS;
    int stall_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bitmap_search_engine_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .chunks_in_use_we (chunks_in_use_we),
        .chunks_in_use    (chunks_in_use),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .chunk_index      (chunk_index),
        .chunk_data       (chunk_data),
        .start_bit        (start_bit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .bit_count        (bit_count),
        .bit_index        (bit_index),
        .found            (found)
    );

    bitmap_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .chunks_in_use_we (chunks_in_use_we),
        .chunks_in_use    (chunks_in_use),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .chunk_index      (chunk_index),
        .chunk_data       (chunk_data),
        .start_bit        (start_bit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .bit_count        (bit_count),
        .bit_index        (bit_index),
        .found            (found),
        .mismatch_count   (mismatch_count),
        .results_waiting  (results_waiting),
        .results_checked  (results_checked)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Valid stays high across back-to-back transfers; it only drops for a gap or while waiting for results.
    task automatic issue_command(input logic [3:0] op, input logic [ADDR_W-1:0] idx,
                                 input logic [31:0] data, input logic [POS_W-1:0] from_bit);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= op;
        chunk_index <= idx;
        chunk_data  <= data;
        start_bit   <= from_bit;
        do
            @(posedge clk);
        while (!in_ready);
        commands_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_waiting != 0);
    endtask

    task automatic set_chunk_span(input logic [NCHUNK_W-1:0] span);
        chunks_in_use_we <= 1'b1;
        chunks_in_use    <= span;
        @(posedge clk);
        chunks_in_use_we <= 1'b0;
        cur_span = int'(span);
        span_settings++;
    endtask

    task automatic issue_random_command();
        int                covered;
        int                pick;
        logic [3:0]        op;
        logic [ADDR_W-1:0] idx;
        logic [31:0]       data;
        logic [POS_W-1:0]  from_bit;
        covered = (cur_span > NUM_CHUNKS) ? NUM_CHUNKS : cur_span;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            op = OP_WRITE;
        else if (pick < 22)
            op = OP_OR;
        else if (pick < 32)
            op = OP_AND;
        else if (pick < 42)
            op = OP_XOR;
        else if (pick < 48)
            op = OP_INVERT;
        else if (pick < 50)
            op = OP_CLEAR;
        else if (pick < 53)
            op = OP_FILL;
        else if (pick < 61)
            op = OP_COUNT;
        else if (pick < 72)
            op = OP_FSET;
        else if (pick < 83)
            op = OP_FZERO;
        else if (pick < 97)
            op = OP_READ;
        else
            op = 4'($urandom_range(CMD_FIRST_SPARE, CMD_TOP));
        // Sparse data keeps lone ones and lone zeros around for the finds to hit.
        case ($urandom_range(0, 3))
            0: data = $urandom;
            1: data = 32'd1 << $urandom_range(0, 31);
            2: data = ~(32'd1 << $urandom_range(0, 31));
            default: data = $urandom_range(0, 1) ? '1 : '0;
        endcase
        if (covered > 0 && $urandom_range(0, 99) < 70)
        begin
            idx = ADDR_W'($urandom_range(0, covered - 1));
            from_bit = POS_W'($urandom_range(0, covered * CHUNK_BITS - 1));
        end
        else
        begin
            idx = ADDR_W'($urandom_range(0, NUM_CHUNKS - 1));
            from_bit = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end
        issue_command(op, idx, data, from_bit);
    endtask

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [NCHUNK_W-1:0] first_spans [4];
        logic [NCHUNK_W-1:0] span;
        first_spans = '{7'd64, 7'd1, 7'd127, 7'd0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass over the full map as it comes out of reset.
        issue_command(OP_READ, 6'd0, '0, '0);
        issue_command(OP_COUNT, '0, '0, '0);
        issue_command(OP_FSET, '0, '0, '0);
        issue_command(OP_FZERO, '0, '0, '0);
        issue_command(OP_FILL, '0, '0, '0);
        issue_command(OP_COUNT, '0, '0, '0);
        issue_command(OP_FZERO, '0, '0, '0);
        issue_command(OP_WRITE, 6'd63, '0, '0);
        issue_command(OP_FZERO, '0, '0, '1);
        issue_command(OP_FSET, '0, '0, '1);
        issue_command(OP_INVERT, 6'd5, '1, '0);
        issue_command(OP_FZERO, '0, '0, '0);
        issue_command(OP_WRITE, 6'd10, 32'hA5A5_A5A5, '0);
        issue_command(OP_OR, 6'd10, 32'h0F0F_0000, '0);
        issue_command(OP_AND, 6'd10, 32'hFF00_FF00, '0);
        issue_command(OP_XOR, 6'd10, '1, '0);
        issue_command(OP_READ, 6'd10, '0, '0);
        issue_command(OP_INVERT, 6'd7, '0, '0);
        issue_command(OP_READ, 6'd63, '0, '0);
        issue_command(CMD_FIRST_SPARE, 6'd7, '1, '1);
        issue_command(CMD_TOP, '1, '1, '1);
        issue_command(OP_CLEAR, '0, '0, '0);
        issue_command(OP_COUNT, '0, '0, '0);

        // A find that starts past the single chunk in use must come back empty.
        wait_for_results();
        set_chunk_span(7'd1);
        issue_command(OP_FILL, '0, '0, '0);
        issue_command(OP_FSET, '0, '0, 11'd40);
        issue_command(OP_FZERO, '0, '0, 11'd5);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 27;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                if (phase == 0)
                    span = first_spans[blk];
                else if ($urandom_range(0, 9) == 0)
                    span = '0;
                else if ($urandom_range(0, 4) == 0)
                    span = NCHUNK_W'($urandom_range(NUM_CHUNKS + 1, (1 << NCHUNK_W) - 1));
                else
                    span = NCHUNK_W'($urandom_range(1, NUM_CHUNKS));
                wait_for_results();
                set_chunk_span(span);
                repeat (BLOCK_ITEMS) issue_random_command();
            end
        end

        wait_for_results();
        repeat (NUM_CHUNKS + 16) @(posedge clk);
        $display("Sent %0d commands under %0d chunk span settings, three idle patterns.",
                 commands_sent, span_settings);
        $display("Compared %0d results field by field, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && results_waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
